### src/bilinear_resize_grad_scatter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear resize gradient scatter
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_RESIZE_GRAD_SCATTER_MACROS_SVH
`define BILINEAR_RESIZE_GRAD_SCATTER_MACROS_SVH

// Same-cycle implication.
`define BRG_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BRG_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/brg_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear resize gradient scatter package
// Shared constants, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package brg_pkg;

   localparam int DEF_MAX_OUT_DIM  = 256;
   localparam int DEF_PLANE_DEPTH  = 65536;
   localparam int DEF_MAX_GRAD_DIM = 256;

   localparam int DIM_W   = 13;
   localparam int CFG_W   = 24;
   localparam int GRAD_W  = 32;
   localparam int SUM_W   = 40;
   localparam int INDEX_W = 16;

   localparam logic [16:0] ONE_Q16  = 17'h10000;
   localparam logic [16:0] HALF_Q16 = 17'h08000;

   localparam logic [2:0] REG_GRAD_HEIGHT  = 3'd0;
   localparam logic [2:0] REG_GRAD_WIDTH   = 3'd1;
   localparam logic [2:0] REG_OUT_HEIGHT   = 3'd2;
   localparam logic [2:0] REG_OUT_WIDTH    = 3'd3;
   localparam logic [2:0] REG_HEIGHT_SCALE = 3'd4;
   localparam logic [2:0] REG_WIDTH_SCALE  = 3'd5;
   localparam logic [2:0] REG_HALF_PIXEL   = 3'd6;

   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_CLEAR      = 1'b1;

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_ROW   = 10'b0000000100,
      S_COL   = 10'b0000001000,
      S_CMAP  = 10'b0000010000,
      S_WMUL  = 10'b0000100000,
      S_GMUL  = 10'b0001000000,
      S_AMUL  = 10'b0010000000,
      S_RADDR = 10'b0100000000,
      S_UPD   = 10'b1000000000
   } state_type;

endpackage

### src/brg_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module brg_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bilinear_resize_grad_scatter.sv
// ----------------------------------------------------------------------------
// Bilinear resize gradient scatter
// Back-propagates a bilinear resize of one plane into an accumulator memory.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An accumulate item
// carries one Q16.16 gradient sample; its place in the plane comes from the
// internal row and column counters, which advance in raster order. A clear
// item zeroes the accumulator memory and restarts the counters.
// Each accumulate item produces four results, top-left, top-right,
// bottom-left and bottom-right, each shown for one cycle with rsp_valid high.
// The fourth carries rsp_last. The receiver cannot stall the block.
// One shared multiplier does all products: the row, column and column-map
// states map the row and column, then each of the four updates runs through
// weight, scaled sample, row address, memory read and read-modify-write. An
// accumulate item keeps busy high until its fourth update is written.
// After reset, and after every clear item, a clearing pass writes zero to
// every memory entry, one entry per cycle; busy stays high meanwhile.
// Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module bilinear_resize_grad_scatter
   import brg_pkg::*;
#(
   parameter int MAX_OUT_DIM  = DEF_MAX_OUT_DIM,
   parameter int PLANE_DEPTH  = DEF_PLANE_DEPTH,
   parameter int MAX_GRAD_DIM = DEF_MAX_GRAD_DIM
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_op,
   input  logic signed [GRAD_W-1:0]  req_grad_value,
   input  logic                      csr_write,
   input  logic [2:0]                csr_index,
   input  logic [CFG_W-1:0]          csr_wdata,
   output logic                      rsp_valid,
   output logic [INDEX_W-1:0]        rsp_out_index,
   output logic signed [SUM_W-1:0]   rsp_out_value,
   output logic                      rsp_last
);

`include "bilinear_resize_grad_scatter_macros.svh"

   localparam int GCW = $clog2(MAX_GRAD_DIM);
   localparam int OCW = $clog2(MAX_OUT_DIM);
   localparam int AW  = $clog2(PLANE_DEPTH);

   logic [8:0]       grad_height_ff, grad_width_ff, out_height_ff, out_width_ff;
   logic [CFG_W-1:0] height_scale_ff, width_scale_ff;
   logic             half_pixel_ff;

   state_type state_ff, state_in;
   logic [GCW-1:0] row_ff, row_in, col_ff, col_in;
   logic [1:0]     k_ff, k_in;
   logic [AW-1:0]  clr_addr_ff, clr_addr_in;
   logic signed [GRAD_W-1:0] grad_ff, grad_in;

   logic [OCW-1:0] top_ff, top_in, bot_ff, bot_in, left_ff, left_in, right_ff, right_in;
   logic [15:0]    ly_ff, ly_in, lx_ff, lx_in;
   logic signed [33:0] contrib_ff, contrib_in;
   logic [AW-1:0]  addr_ff, addr_in;

   logic signed [57:0] prod_ff, prod_in;
   logic signed [32:0] mul_a;
   logic signed [24:0] mul_b;

   logic               rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic signed [SUM_W-1:0] rsp_value_ff, rsp_value_in;

   logic [DIM_W-1:0] gh, gw, oh, ow;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [SUM_W-1:0] ram_wdata, ram_rdata;

   logic [GCW:0]     m_row, m_col;
   logic [OCW-1:0]   map_lo, map_hi;
   logic [15:0]      map_frac;
   logic [16:0]      wy, wx, weight;
   logic [33:0]      wround;
   logic signed [57:0] cround;
   logic signed [41:0] sum_wide;
   logic signed [SUM_W-1:0] sum_sat;
   logic             accept, wrap_col, wrap_row;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [8:0] raw, input int maxv);
      logic [DIM_W-1:0] res;
      if (raw == 9'd0) begin
         res = DIM_W'(1);
      end else if (32'(raw) > maxv) begin
         res = DIM_W'(maxv);
      end else begin
         res = DIM_W'(raw);
      end
      return res;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_idx(input logic signed [23:0] v,
                                                  input logic [DIM_W-1:0] dim);
      logic signed [23:0] top;
      logic [DIM_W-1:0]   res;
      top = $signed(24'(dim)) - 24'sd1;
      if (v < 0) begin
         res = '0;
      end else if (v > top) begin
         res = top[DIM_W-1:0];
      end else begin
         res = v[DIM_W-1:0];
      end
      return res;
   endfunction

   always_comb begin
      gh = eff_dim(grad_height_ff, MAX_GRAD_DIM);
      gw = eff_dim(grad_width_ff, MAX_GRAD_DIM);
      oh = eff_dim(out_height_ff, MAX_OUT_DIM);
      ow = eff_dim(out_width_ff, MAX_OUT_DIM);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grad_height_ff  <= 9'd1;
         grad_width_ff   <= 9'd1;
         out_height_ff   <= 9'd1;
         out_width_ff    <= 9'd1;
         height_scale_ff <= CFG_W'(ONE_Q16);
         width_scale_ff  <= CFG_W'(ONE_Q16);
         half_pixel_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_GRAD_HEIGHT:  grad_height_ff  <= csr_wdata[8:0];
            REG_GRAD_WIDTH:   grad_width_ff   <= csr_wdata[8:0];
            REG_OUT_HEIGHT:   out_height_ff   <= csr_wdata[8:0];
            REG_OUT_WIDTH:    out_width_ff    <= csr_wdata[8:0];
            REG_HEIGHT_SCALE: height_scale_ff <= csr_wdata;
            REG_WIDTH_SCALE:  width_scale_ff  <= csr_wdata;
            REG_HALF_PIXEL:   half_pixel_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Axis mapping from the registered coordinate product.
   always_comb begin
      logic [36:0]        p;
      logic signed [38:0] c;
      logic signed [23:0] fl, ce;
      logic [DIM_W-1:0]   dim;
      p   = prod_ff[36:0];
      dim = state_ff == S_COL ? oh : ow;
      if (half_pixel_ff) begin
         c = $signed({3'b000, p[36:1]}) - $signed(39'(HALF_Q16));
      end else begin
         c = $signed({2'b00, p});
      end
      fl = 24'(c >>> 16);
      ce = fl + ((c[15:0] != 16'd0) ? 24'sd1 : 24'sd0);
      map_lo   = OCW'(clamp_idx(fl, dim));
      map_hi   = OCW'(clamp_idx(ce, dim));
      map_frac = c[15:0];
   end

   always_comb begin
      m_row  = half_pixel_ff ? {row_ff, 1'b1} : {1'b0, row_ff};
      m_col  = half_pixel_ff ? {col_ff, 1'b1} : {1'b0, col_ff};
      wy     = k_ff[1] ? {1'b0, ly_ff} : ONE_Q16 - {1'b0, ly_ff};
      wx     = k_ff[0] ? {1'b0, lx_ff} : ONE_Q16 - {1'b0, lx_ff};
      wround = prod_ff[33:0] + 34'(HALF_Q16);
      weight = wround[32:16];
      cround = prod_ff + 58'(HALF_Q16);
      unique case (state_ff)
         S_ROW: begin
            mul_a = $signed(33'(m_row));
            mul_b = $signed({1'b0, height_scale_ff});
         end
         S_COL: begin
            mul_a = $signed(33'(m_col));
            mul_b = $signed({1'b0, width_scale_ff});
         end
         S_WMUL: begin
            mul_a = $signed(33'(wy));
            mul_b = $signed(25'(wx));
         end
         S_GMUL: begin
            mul_a = 33'(grad_ff);
            mul_b = $signed(25'(weight));
         end
         S_AMUL: begin
            mul_a = $signed(33'(k_ff[1] ? bot_ff : top_ff));
            mul_b = $signed(25'(ow));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = 58'(mul_a * mul_b);
   end

   always_comb begin
      sum_wide = 42'($signed(ram_rdata)) + 42'(contrib_ff);
      if (sum_wide > 42'sh07F_FFFF_FFFF) begin
         sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
      end else if (sum_wide < -42'sh080_0000_0000) begin
         sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   assign accept   = start && (state_ff == S_IDLE);
   assign wrap_col = 32'(col_ff) + 1 >= 32'(gw);
   assign wrap_row = 32'(row_ff) + 1 >= 32'(gh);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      k_in         = k_ff;
      clr_addr_in  = clr_addr_ff;
      grad_in      = grad_ff;
      top_in       = top_ff;
      bot_in       = bot_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      ly_in        = ly_ff;
      lx_in        = lx_ff;
      contrib_in   = contrib_ff;
      addr_in      = addr_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = sum_sat;
      ram_raddr    = AW'(prod_ff[23:0] + 24'(k_ff[0] ? right_ff : left_ff));
      unique case (state_ff)
         S_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (32'(clr_addr_ff) == PLANE_DEPTH - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_CLEAR) begin
                  row_in      = '0;
                  col_in      = '0;
                  clr_addr_in = '0;
                  state_in    = S_CLEAR;
               end else begin
                  grad_in  = req_grad_value;
                  k_in     = 2'd0;
                  state_in = S_ROW;
               end
            end
         end
         S_ROW: begin
            state_in = S_COL;
         end
         S_COL: begin
            top_in   = map_lo;
            bot_in   = map_hi;
            ly_in    = map_frac;
            state_in = S_CMAP;
         end
         S_CMAP: begin
            left_in  = map_lo;
            right_in = map_hi;
            lx_in    = map_frac;
            state_in = S_WMUL;
         end
         S_WMUL: begin
            state_in = S_GMUL;
         end
         S_GMUL: begin
            state_in = S_AMUL;
         end
         S_AMUL: begin
            contrib_in = cround[49:16];
            state_in   = S_RADDR;
         end
         S_RADDR: begin
            addr_in  = ram_raddr;
            state_in = S_UPD;
         end
         S_UPD: begin
            ram_we       = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_last_in  = k_ff == 2'd3;
            rsp_index_in = INDEX_W'(addr_ff);
            rsp_value_in = sum_sat;
            k_in         = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = S_IDLE;
               if (wrap_col) begin
                  col_in = '0;
                  row_in = wrap_row ? '0 : row_ff + GCW'(1);
               end else begin
                  col_in = col_ff + GCW'(1);
               end
            end else begin
               state_in = S_WMUL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         row_ff       <= '0;
         col_ff       <= '0;
         k_ff         <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         k_ff         <= k_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      grad_ff      <= grad_in;
      top_ff       <= top_in;
      bot_ff       <= bot_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      ly_ff        <= ly_in;
      lx_ff        <= lx_in;
      contrib_ff   <= contrib_in;
      addr_ff      <= addr_in;
      prod_ff      <= prod_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
   end

   brg_ram #(
      .WIDTH (SUM_W),
      .DEPTH (PLANE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy          = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_value = rsp_value_ff;

   `BRG_ASSERT_IMP(a_rsp_after_update, rsp_valid, $past(state_ff == S_UPD), "result without update")
   `BRG_ASSERT_NXT(a_accumulate_starts, accept && !req_op, state_ff == S_ROW, "accumulate not started")
   `BRG_ASSERT_NXT(a_clear_starts, accept && req_op, state_ff == S_CLEAR, "clear not started")
   `BRG_ASSERT_IMP(a_last_ends_item, rsp_valid && rsp_last, state_ff == S_IDLE, "last while busy")

endmodule
